/* rtl/core/fcc_pkg.sv */
// Shared types, constants and helpers of the fan curve controller.
// No dependencies; used by fcc_div and fan_curve_controller_core.

package fcc_pkg;

    // Serial divider operand widths
    localparam int DIV_N_W = 19;
    localparam int DIV_D_W = 10;

    // Curve storage is fixed at eight packed bytes
    localparam int CURVE_W        = 64;
    localparam int CURVE_SLOTS    = 8;
    localparam int DEFAULT_MAX_POINTS = 8;

    // Field widths
    localparam int TEMP_IN_W = 18;
    localparam int DEG_W     = 11;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Millidegrees to degrees: q = (m * RECIP_1000) >> RECIP_SHIFT,
    // exact for every 18 bit input magnitude (up to 2^17)
    localparam int                 RECIP_W     = 19;
    localparam int                 RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 19'd268436;

    // Constants
    localparam logic [DUTY_W-1:0]  DUTY_FULL     = 8'd255;

    // Register reset values
    localparam logic [7:0] START_TEMP_RST = 8'd50;
    localparam logic [7:0] HYST_RST       = 8'd2;
    localparam logic [7:0] EMERG_TEMP_RST = 8'd85;
    localparam logic [3:0] POINT_CNT_RST  = 4'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TEMP   = 3'd0,
        CFG_HYSTERESIS   = 3'd1,
        CFG_EMERG_TEMP   = 3'd2,
        CFG_POINT_COUNT  = 3'd3,
        CFG_CURVE_TEMPS  = 3'd4,
        CFG_CURVE_DUTIES = 3'd5
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TDIV,
        S_DECIDE,
        S_CURVE,
        S_WALK,
        S_MUL1,
        S_MUL2,
        S_DSET,
        S_DWAIT,
        S_FINISH
    } state_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_N_W-1:0]  quotient;
    } div_stat_t;

    // Byte i of a packed curve word
    function automatic logic [7:0] point_byte(input logic [CURVE_W-1:0] word,
                                              input logic [2:0] idx);
        point_byte = word[idx*8 +: 8];
    endfunction

endpackage

/* rtl/core/fcc_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on fcc_pkg for operand widths and the status struct.

module fcc_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fcc_pkg::DIV_N_W-1:0]    dividend,
    input  logic [fcc_pkg::DIV_D_W-1:0]    divisor,
    output fcc_pkg::div_stat_t             stat
);

    localparam int N_W   = fcc_pkg::DIV_N_W;
    localparam int D_W   = fcc_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [D_W:0]     shifted;
    logic [D_W+1:0]   trial;
    logic             qbit;

    // Trial subtraction of one step
    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};
    assign qbit    = ~trial[D_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N_W-2:0], qbit};
            rem_reg <= qbit ? trial[D_W-1:0] : shifted[D_W-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

/* rtl/core/fan_curve_controller_core.sv */
// Fan curve controller top level: configuration registers, sequencer, datapath.
// Depends on fcc_pkg and fcc_div.

// Takes one temperature sample in millidegrees and returns one fan duty item
// with a write strobe and an emergency flag. A sample is turned into whole
// degrees by a reciprocal multiply and registered; an emergency or held duty is
// then decided and such an item is loaded into the output register, as is a
// curve answer from the zero region or an end point. An interpolated duty adds
// a segment walk of one point per cycle (one to MAX_POINTS-1), the multiply
// states S_MUL1 and S_MUL2, the set-up state S_DSET and the 19-step serial
// divider. The input is stalled from acceptance until the result is loaded
// into the output register, and the next sample can be accepted in the cycle
// after; a result left waiting there does not stop the next sample from being
// taken.
// Configuration writes are always accepted and must be made while idle.

module fan_curve_controller_core
#(
    parameter int MAX_POINTS = fcc_pkg::DEFAULT_MAX_POINTS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [fcc_pkg::TEMP_IN_W-1:0] temp_millideg,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fcc_pkg::DUTY_W-1:0]           duty,
    output logic                                 write_strobe,
    output logic                                 emergency,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fcc_pkg::CFG_DAT_W-1:0]        cfg_data
);

    localparam int PIDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DEG_W      = fcc_pkg::DEG_W;
    localparam int N_W        = fcc_pkg::DIV_N_W;
    localparam int D_W        = fcc_pkg::DIV_D_W;
    localparam int TEMP_MAG_W = fcc_pkg::TEMP_IN_W;
    localparam int PROD_W     = TEMP_MAG_W + fcc_pkg::RECIP_W;
    localparam int QDEG_W     = PROD_W - fcc_pkg::RECIP_SHIFT;

    // Configuration registers
    logic [7:0]                    start_temp_reg;
    logic [7:0]                    hyst_reg;
    logic [7:0]                    emerg_temp_reg;
    logic [3:0]                    point_cnt_reg;
    logic [fcc_pkg::CURVE_W-1:0]   curve_temps_reg;
    logic [fcc_pkg::CURVE_W-1:0]   curve_duties_reg;

    // Sequencer and state
    fcc_pkg::state_t               state_reg, state_next;
    logic                          ev_valid_reg;
    logic signed [DEG_W-1:0]       last_eval_reg;
    logic                          wr_valid_reg;
    logic [7:0]                    last_wr_reg;

    // Working registers
    logic                          neg_in_reg;
    logic [TEMP_MAG_W-1:0]         mag_reg;
    logic signed [DEG_W-1:0]       temp_reg;
    logic [PIDX_W-1:0]             idx_reg;
    logic [7:0]                    tl_reg;
    logic [7:0]                    dl_reg;
    logic [7:0]                    dh_reg;
    logic signed [8:0]             dt_reg;
    logic signed [19:0]            acc_reg;
    logic                          neg_q_reg;
    logic [7:0]                    duty_reg;
    logic                          emerg_reg;

    // Output register
    logic                          out_valid_reg;
    logic [7:0]                    out_duty_reg;
    logic                          out_strobe_reg;
    logic                          out_emerg_reg;

    // Control strobes
    logic                          div_start;
    logic                          out_load;

    fcc_pkg::div_stat_t            div_stat;
    logic [N_W-1:0]                div_dividend;
    logic [D_W-1:0]                div_divisor;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_temp_reg   <= fcc_pkg::START_TEMP_RST;
            hyst_reg         <= fcc_pkg::HYST_RST;
            emerg_temp_reg   <= fcc_pkg::EMERG_TEMP_RST;
            point_cnt_reg    <= fcc_pkg::POINT_CNT_RST;
            curve_temps_reg  <= '0;
            curve_duties_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fcc_pkg::CFG_START_TEMP:   start_temp_reg   <= cfg_data[7:0];
                fcc_pkg::CFG_HYSTERESIS:   hyst_reg         <= cfg_data[7:0];
                fcc_pkg::CFG_EMERG_TEMP:   emerg_temp_reg   <= cfg_data[7:0];
                fcc_pkg::CFG_POINT_COUNT:  point_cnt_reg    <= cfg_data[3:0];
                fcc_pkg::CFG_CURVE_TEMPS:  curve_temps_reg  <= cfg_data;
                fcc_pkg::CFG_CURVE_DUTIES: curve_duties_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Derived values
    logic [3:0]              n_eff;
    logic [PIDX_W-1:0]       last_idx;
    logic [PIDX_W-1:0]       idx_lo;
    logic [7:0]              t_first, d_first, t_last, d_last;
    logic [7:0]              t_hi, d_hi, t_lo, d_lo;
    logic signed [DEG_W-1:0] start_ext, emerg_ext;
    logic signed [DEG_W-1:0] t_first_ext, t_last_ext, t_hi_ext;
    logic signed [DEG_W-1:0] temp_deg;
    logic signed [DEG_W-1:0] temp_diff;
    logic [DEG_W-1:0]        diff_mag;
    logic                    do_eval;
    logic [TEMP_MAG_W-1:0]   in_mag;
    logic [PROD_W-1:0]       recip_prod;
    logic [QDEG_W-1:0]       deg_mag;

    assign n_eff    = (point_cnt_reg > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : point_cnt_reg;
    assign last_idx = PIDX_W'(n_eff - 4'd1);
    assign idx_lo   = idx_reg - 1'b1;

    assign t_first = fcc_pkg::point_byte(curve_temps_reg, 3'd0);
    assign d_first = fcc_pkg::point_byte(curve_duties_reg, 3'd0);
    assign t_last  = fcc_pkg::point_byte(curve_temps_reg, 3'(last_idx));
    assign d_last  = fcc_pkg::point_byte(curve_duties_reg, 3'(last_idx));
    assign t_hi    = fcc_pkg::point_byte(curve_temps_reg, 3'(idx_reg));
    assign d_hi    = fcc_pkg::point_byte(curve_duties_reg, 3'(idx_reg));
    assign t_lo    = fcc_pkg::point_byte(curve_temps_reg, 3'(idx_lo));
    assign d_lo    = fcc_pkg::point_byte(curve_duties_reg, 3'(idx_lo));

    assign start_ext   = {{3{start_temp_reg[7]}}, start_temp_reg};
    assign emerg_ext   = {{3{emerg_temp_reg[7]}}, emerg_temp_reg};
    assign t_first_ext = {3'b000, t_first};
    assign t_last_ext  = {3'b000, t_last};
    assign t_hi_ext    = {3'b000, t_hi};

    // Degrees from the sample magnitude by reciprocal multiply, truncated toward zero
    assign recip_prod = PROD_W'(mag_reg) * PROD_W'(fcc_pkg::RECIP_1000);
    assign deg_mag    = recip_prod[PROD_W-1:fcc_pkg::RECIP_SHIFT];
    assign temp_deg   = neg_in_reg ? -DEG_W'(deg_mag) : DEG_W'(deg_mag);

    // Hysteresis test
    assign temp_diff = temp_reg - last_eval_reg;
    assign diff_mag  = temp_diff[DEG_W-1] ? DEG_W'(-temp_diff) : DEG_W'(temp_diff);
    assign do_eval   = !ev_valid_reg || (diff_mag >= {3'b000, hyst_reg});

    // Magnitude of the incoming sample
    assign in_mag = temp_millideg[TEMP_MAG_W-1] ? TEMP_MAG_W'(-temp_millideg)
                                                : TEMP_MAG_W'(temp_millideg);

    // Divider operand set-up for the interpolation
    logic [19:0]  num_mag;
    logic [7:0]   dt_mag;
    logic [N_W-1:0] interp_dividend;

    assign num_mag = acc_reg[19] ? 20'(-acc_reg) : 20'(acc_reg);
    assign dt_mag  = dt_reg[8] ? 8'(-dt_reg) : 8'(dt_reg);
    assign interp_dividend = {num_mag[N_W-2:0], 1'b0} + N_W'(dt_mag);

    assign div_dividend = interp_dividend;
    assign div_divisor  = {1'b0, dt_mag, 1'b0};

    fcc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat)
    );

    // Walk and segment arithmetic
    logic                    seg_found;
    logic signed [DEG_W-1:0] dtemp;
    logic signed [8:0]       dduty;
    logic signed [19:0]      prod2;
    logic signed [17:0]      prod1;
    logic [7:0]              interp_duty;
    logic [7:0]              strobe_duty;
    logic                    strobe;

    assign seg_found = (temp_reg <= t_hi_ext) || (idx_reg == last_idx);
    assign dtemp     = temp_reg - $signed({3'b000, tl_reg});
    assign dduty     = $signed({1'b0, dh_reg}) - $signed({1'b0, dl_reg});
    assign prod1     = $signed({1'b0, dl_reg}) * dt_reg;
    assign prod2     = dtemp * dduty;

    // Rounded quotient, clamped to the duty range
    assign interp_duty = neg_q_reg ? 8'd0
                       : (|div_stat.quotient[N_W-1:8]) ? fcc_pkg::DUTY_FULL
                       : div_stat.quotient[7:0];

    assign strobe_duty = duty_reg;
    assign strobe      = (strobe_duty != 8'd0) &&
                         (!wr_valid_reg || (strobe_duty != last_wr_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcc_pkg::S_IDLE:
                if (in_valid)
                    state_next = fcc_pkg::S_TDIV;
            fcc_pkg::S_TDIV:
                state_next = fcc_pkg::S_DECIDE;
            fcc_pkg::S_DECIDE:
                if (temp_reg >= emerg_ext || !do_eval)
                    state_next = fcc_pkg::S_FINISH;
                else
                    state_next = fcc_pkg::S_CURVE;
            fcc_pkg::S_CURVE:
                if (temp_reg <= start_ext || n_eff == 4'd0 ||
                    temp_reg <= t_first_ext || temp_reg >= t_last_ext)
                    state_next = fcc_pkg::S_FINISH;
                else
                    state_next = fcc_pkg::S_WALK;
            fcc_pkg::S_WALK:
                if (seg_found)
                    state_next = (t_hi == t_lo) ? fcc_pkg::S_FINISH : fcc_pkg::S_MUL1;
            fcc_pkg::S_MUL1:
                state_next = fcc_pkg::S_MUL2;
            fcc_pkg::S_MUL2:
                state_next = fcc_pkg::S_DSET;
            fcc_pkg::S_DSET:
                state_next = fcc_pkg::S_DWAIT;
            fcc_pkg::S_DWAIT:
                if (div_stat.done)
                    state_next = fcc_pkg::S_FINISH;
            fcc_pkg::S_FINISH:
                if (out_load)
                    state_next = fcc_pkg::S_IDLE;
            default:
                state_next = fcc_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall     = 1'b1;
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            fcc_pkg::S_IDLE:
                in_stall = 1'b0;
            fcc_pkg::S_DSET:
                div_start = 1'b1;
            fcc_pkg::S_FINISH:
                out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Controller state: last evaluated temperature and last written duty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            last_eval_reg <= '0;
            wr_valid_reg  <= 1'b0;
            last_wr_reg   <= '0;
        end
        else
        begin
            if (state_reg == fcc_pkg::S_DECIDE && temp_reg < emerg_ext && do_eval)
            begin
                ev_valid_reg  <= 1'b1;
                last_eval_reg <= temp_reg;
            end
            if (out_load && strobe)
            begin
                wr_valid_reg <= 1'b1;
                last_wr_reg  <= strobe_duty;
            end
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fcc_pkg::S_IDLE:
            begin
                neg_in_reg <= temp_millideg[fcc_pkg::TEMP_IN_W-1];
                mag_reg    <= in_mag;
            end
            fcc_pkg::S_TDIV:
                temp_reg <= temp_deg;
            fcc_pkg::S_DECIDE:
            begin
                emerg_reg <= 1'b0;
                if (temp_reg >= emerg_ext)
                begin
                    duty_reg  <= fcc_pkg::DUTY_FULL;
                    emerg_reg <= 1'b1;
                end
                else if (!do_eval)
                    duty_reg <= wr_valid_reg ? last_wr_reg : 8'd0;
            end
            fcc_pkg::S_CURVE:
            begin
                idx_reg <= PIDX_W'(1);
                if (temp_reg <= start_ext || n_eff == 4'd0)
                    duty_reg <= 8'd0;
                else if (temp_reg <= t_first_ext)
                    duty_reg <= d_first;
                else if (temp_reg >= t_last_ext)
                    duty_reg <= d_last;
            end
            fcc_pkg::S_WALK:
            begin
                if (seg_found)
                begin
                    tl_reg   <= t_lo;
                    dl_reg   <= d_lo;
                    dh_reg   <= d_hi;
                    dt_reg   <= $signed({1'b0, t_hi}) - $signed({1'b0, t_lo});
                    duty_reg <= d_lo;
                end
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            fcc_pkg::S_MUL1:
                acc_reg <= 20'(prod1);
            fcc_pkg::S_MUL2:
                acc_reg <= acc_reg + prod2;
            fcc_pkg::S_DSET:
                neg_q_reg <= acc_reg[19] ^ dt_reg[8];
            fcc_pkg::S_DWAIT:
                if (div_stat.done)
                    duty_reg <= interp_duty;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_duty_reg   <= duty_reg;
            out_strobe_reg <= strobe;
            out_emerg_reg  <= emerg_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty         = out_duty_reg;
    assign write_strobe = out_strobe_reg;
    assign emergency    = out_emerg_reg;

endmodule
